// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL file that checks its own behavior.
// Every check is sampled on the rising edge of aclk and is held off while
// aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever cond holds, expect holds too.
`define ASSERT_IMPLIES(label, cond, expect_c, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (expect_c)) else $error(msg);

// Next-cycle implication: whenever cond holds, expect holds in the next cycle.
`define ASSERT_NEXT(label, cond, expect_c, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (expect_c)) else $error(msg);

`endif

// ===== hw/rtl/imm_pkg.sv =====
package imm_pkg;

    // Pairs skipped at the head of a packet whose first word is invalid.
    localparam logic [8:0] SKIP_PAIRS = 9'd2;

    // Pair position saturates here.
    localparam logic [8:0] POS_MAX = 9'd511;

    // Result kinds.
    localparam logic KIND_MAGNITUDE = 1'b0;
    localparam logic KIND_SUMMARY   = 1'b1;

    typedef struct packed {
        logic signed [7:0] in_phase;
        logic signed [7:0] quadrature;
        logic              skip_first;
        logic              last_pair;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  subcarrier_index;
        logic [15:0] magnitude;
        logic [15:0] mean_magnitude;
        logic [8:0]  kept_count;
        logic        last_result;
    } out_item_t;

    // Status of an iterative arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_MAG_OUT,
        ST_END,
        ST_DIV,
        ST_SUM_OUT
    } state_t;

endpackage

// ===== hw/rtl/imm_isqrt.sv =====
module imm_isqrt (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [15:0]           power,
    output logic [15:0]           root,
    output imm_pkg::unit_status_t status
);

    // Digit-by-digit square root of {power, 16'h0000}: two radicand bits
    // enter per cycle and one root bit leaves.
    logic [31:0] rad_reg, rad_next;
    logic [17:0] rem_reg, rem_next;
    logic [15:0] root_reg, root_next;
    logic [3:0]  count_reg, count_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [17:0] rem_shift;
    logic [17:0] trial;

    // The remainder never exceeds twice the partial root, so its top two
    // bits are zero before the shift.
    assign rem_shift = {rem_reg[15:0], rad_reg[31:30]};
    assign trial     = {root_reg, 2'b01};

    always_comb begin
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            rad_next   = {power, 16'h0000};
            rem_next   = '0;
            root_next  = '0;
            count_next = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[29:0], 2'b00};
            if (rem_shift >= trial) begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[14:0], 1'b1};
            end else begin
                rem_next  = rem_shift;
                root_next = {root_reg[14:0], 1'b0};
            end
            count_next = count_reg + 4'd1;
            if (count_reg == 4'hF) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root        = root_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== hw/rtl/imm_div.sv =====
module imm_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [23:0]           dividend,
    input  logic [8:0]            divisor,
    output logic [15:0]           quotient,
    output imm_pkg::unit_status_t status
);

    // Restoring division, one quotient bit per cycle. Dividend bits leave
    // the top of the shift register while quotient bits enter at the bottom.
    localparam int          DIV_STEPS = 24;
    localparam logic [4:0]  LAST_STEP = 5'(DIV_STEPS - 1);

    logic [23:0] shift_reg, shift_next;
    logic [8:0]  rem_reg, rem_next;
    logic [8:0]  divisor_reg, divisor_next;
    logic [4:0]  count_reg, count_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [9:0]  partial;
    logic        fits;

    assign partial = {rem_reg, shift_reg[23]};
    assign fits    = partial >= {1'b0, divisor_reg};

    always_comb begin
        shift_next   = shift_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        count_next   = count_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (start) begin
            shift_next   = dividend;
            rem_next     = '0;
            divisor_next = divisor;
            count_next   = '0;
            busy_next    = 1'b1;
        end else if (busy_reg) begin
            // The remainder stays below the divisor, so nine bits hold it.
            if (fits) begin
                rem_next = 9'(partial - {1'b0, divisor_reg});
            end else begin
                rem_next = partial[8:0];
            end
            shift_next = {shift_reg[22:0], fits};
            count_next = count_reg + 5'd1;
            if (count_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        shift_reg   <= shift_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    // The mean never exceeds the largest magnitude, so sixteen bits suffice.
    assign quotient    = shift_reg[15:0];
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== hw/rtl/iq_magnitude_and_mean.sv =====
// Channel   Direction  Handshake          Payload
// s_        input      s_valid / s_ready  s_item  (imm_pkg::in_item_t)
// m_        output     m_valid / m_ready  m_item  (imm_pkg::out_item_t)
//
// A kept pair is accepted, runs through the bit-serial square-root unit, and
// its magnitude item is then loaded into the output register once that is free.
// For a pair marked last the summary follows, computed by the 24-step serial
// divider; a packet with no kept pairs skips the divider.
// A dropped pair that is not last is absorbed without leaving the idle state.
// Reset is synchronous on aresetn low and clears the packet state and the output valid flag.
// The next item is taken while a finished item still waits in the output register;
// work stalls only when a new item must be loaded and the register is still full.
`include "assert_macros.svh"

module iq_magnitude_and_mean #(
    parameter int MAX_SUBCARRIERS = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  imm_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output imm_pkg::out_item_t  m_item
);

    localparam logic [8:0] MAX_SC = 9'(MAX_SUBCARRIERS);

    imm_pkg::state_t    state_reg, state_next;
    logic [8:0]         pos_reg, pos_next;
    logic [8:0]         kept_reg, kept_next;
    logic [23:0]        sum_reg, sum_next;
    logic               last_reg, last_next;
    logic [15:0]        mean_reg, mean_next;
    logic               m_valid_reg, m_valid_next;
    imm_pkg::out_item_t m_item_reg, m_item_next;

    logic signed [15:0] i_sq;
    logic signed [15:0] q_sq;
    logic [15:0]        power;
    logic [8:0]         start_pos;
    logic               keep;
    logic               out_free;

    logic                  sq_start;
    logic [15:0]           sq_root;
    imm_pkg::unit_status_t sq_st;
    logic                  dv_start;
    logic [15:0]           dv_quotient;
    imm_pkg::unit_status_t dv_st;

    // The power of one pair is at most 32768, so it fits sixteen unsigned bits.
    assign i_sq  = s_item.in_phase * s_item.in_phase;
    assign q_sq  = s_item.quadrature * s_item.quadrature;
    assign power = $unsigned(i_sq) + $unsigned(q_sq);

    // A pair is kept when it lies past the skipped head and inside the
    // subcarrier window.
    assign start_pos = s_item.skip_first ? imm_pkg::SKIP_PAIRS : 9'd0;
    assign keep      = (pos_reg >= start_pos) && (pos_reg < MAX_SC);

    // The output register can take a new item when empty or being drained.
    assign out_free = !m_valid_reg || m_ready;

    imm_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .power   (power),
        .root    (sq_root),
        .status  (sq_st)
    );

    imm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dv_start),
        .dividend (sum_reg),
        .divisor  (kept_reg),
        .quotient (dv_quotient),
        .status   (dv_st)
    );

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        kept_next    = kept_reg;
        sum_next     = sum_reg;
        last_next    = last_reg;
        mean_next    = mean_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        s_ready      = 1'b0;
        sq_start     = 1'b0;
        dv_start     = 1'b0;

        case (state_reg)
            imm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (pos_reg != imm_pkg::POS_MAX) begin
                        pos_next = pos_reg + 9'd1;
                    end
                    last_next = s_item.last_pair;
                    if (keep) begin
                        sq_start   = 1'b1;
                        state_next = imm_pkg::ST_SQRT;
                    end else if (s_item.last_pair) begin
                        state_next = imm_pkg::ST_END;
                    end
                end
            end
            imm_pkg::ST_SQRT: begin
                if (sq_st.done) begin
                    state_next = imm_pkg::ST_MAG_OUT;
                end
            end
            imm_pkg::ST_MAG_OUT: begin
                // The magnitude item is final unless a summary follows it.
                if (out_free) begin
                    m_valid_next                 = 1'b1;
                    m_item_next.result_kind      = imm_pkg::KIND_MAGNITUDE;
                    m_item_next.subcarrier_index = kept_reg[7:0];
                    m_item_next.magnitude        = sq_root;
                    m_item_next.mean_magnitude   = '0;
                    m_item_next.kept_count       = '0;
                    m_item_next.last_result      = !last_reg;
                    kept_next  = kept_reg + 9'd1;
                    sum_next   = sum_reg + {8'h00, sq_root};
                    state_next = last_reg ? imm_pkg::ST_END : imm_pkg::ST_IDLE;
                end
            end
            imm_pkg::ST_END: begin
                // An empty packet has a mean of zero and needs no division.
                if (kept_reg == 9'd0) begin
                    mean_next  = '0;
                    state_next = imm_pkg::ST_SUM_OUT;
                end else begin
                    dv_start   = 1'b1;
                    state_next = imm_pkg::ST_DIV;
                end
            end
            imm_pkg::ST_DIV: begin
                if (dv_st.done) begin
                    mean_next  = dv_quotient;
                    state_next = imm_pkg::ST_SUM_OUT;
                end
            end
            imm_pkg::ST_SUM_OUT: begin
                if (out_free) begin
                    m_valid_next                 = 1'b1;
                    m_item_next.result_kind      = imm_pkg::KIND_SUMMARY;
                    m_item_next.subcarrier_index = '0;
                    m_item_next.magnitude        = '0;
                    m_item_next.mean_magnitude   = mean_reg;
                    m_item_next.kept_count       = kept_reg;
                    m_item_next.last_result      = 1'b1;
                    pos_next   = '0;
                    kept_next  = '0;
                    sum_next   = '0;
                    state_next = imm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = imm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= imm_pkg::ST_IDLE;
            pos_reg     <= '0;
            kept_reg    <= '0;
            sum_reg     <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            kept_reg    <= kept_next;
            sum_reg     <= sum_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
        mean_reg   <= mean_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // No new item is taken while either arithmetic unit is still iterating.
    `ASSERT_IMPLIES(a_idle_units, s_ready, !(sq_st.busy || dv_st.busy), "unit busy while ready")
    // A root completes only while the controller waits for it.
    `ASSERT_IMPLIES(a_sqrt_done, sq_st.done, state_reg == imm_pkg::ST_SQRT, "stray root done")
    // Kept pairs never outnumber the pairs seen so far in the packet.
    `ASSERT_IMPLIES(a_kept_le_pos, state_reg == imm_pkg::ST_IDLE, kept_reg <= pos_reg, "kept > pos")
    // Loading a summary clears the registered packet state.
    `ASSERT_NEXT(a_sum_clear, state_reg == imm_pkg::ST_SUM_OUT && out_free, kept_reg == 9'd0, "no clear")

endmodule
